### rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Post class classifier package
// Shared types, masks and a helper function for the classifier pipeline.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int TABLE_BITS = 64;
    localparam int VARS_BITS  = 3;
    localparam int LIMIT_VARS = 6;

    typedef logic [TABLE_BITS-1:0] t_table;
    typedef logic [VARS_BITS-1:0]  t_vars;

    // Bit i is set where bit j of the row index i is clear.
    localparam t_table LOW_HALF_MASK [LIMIT_VARS] = '{
        64'h5555555555555555,
        64'h3333333333333333,
        64'h0F0F0F0F0F0F0F0F,
        64'h00FF00FF00FF00FF,
        64'h0000FFFF0000FFFF,
        64'h00000000FFFFFFFF
    };

    // Rows whose index has two or more set bits, i.e. nonlinear ANF terms.
    // Only rows 0, 1, 2, 4, 8, 16 and 32 are clear.
    localparam t_table NONLINEAR_MASK = 64'hFFFFFFFEFFFEFEE8;

    // Mask of the rows that exist for a function of the given number of variables.
    function automatic t_table row_mask(input t_vars vars);
        t_table m;
        m = '1;
        if (vars < t_vars'(LIMIT_VARS)) begin
            m = (t_table'(1) << (7'd1 << vars)) - t_table'(1);
        end
        return m;
    endfunction

endpackage

### rtl/pcc_mobius.sv
// ----------------------------------------------------------------------------
// Post class classifier, Moebius butterfly group
// Applies a range of the XOR butterfly steps that turn a truth table into its
// algebraic normal form. Steps at or above the number of variables are skipped.
// ----------------------------------------------------------------------------
module pcc_mobius
    import pcc_pkg::*;
#(
    parameter int FIRST_STEP = 0,
    parameter int LAST_STEP  = 2
) (
    input  t_table i_table,
    input  t_vars  i_vars,
    output t_table o_table
);

    always_comb begin
        t_table acc;
        acc = i_table;
        for (int j = FIRST_STEP; j <= LAST_STEP; j++) begin
            if (t_vars'(j) < i_vars) begin
                acc = acc ^ ((acc & LOW_HALF_MASK[j]) << (1 << j));
            end
        end
        o_table = acc;
    end

endmodule

### rtl/post_class_classifier.sv
// ----------------------------------------------------------------------------
// Post class classifier
// Reports which of the five Post classes a Boolean function lies outside of.
// ----------------------------------------------------------------------------
// Usage
// An item on the input channel (i_valid / o_ready_in) is a 64-bit truth table:
// bit i holds f at row i, the first variable being the most significant index
// bit. Rows at 2^num_vars and above are ignored. Each item yields exactly one
// result item on the output channel (o_valid / i_ready) carrying five
// non-membership flags and the complete flag, which is set when all five are.
// The num_vars register is written through its own channel (i_cfg_valid /
// o_cfg_ready) and is always ready; write it only while the block is idle.
// Values of zero are treated as one, and values above MAX_VARS as MAX_VARS.
// The work runs through four register stages: input capture and masking, the
// simple checks plus the first three butterfly steps, the last three steps,
// and the linearity test into the output register. Items pass through them
// in order; one item may enter every cycle while o_ready_in is high.
// Synchronous reset empties the pipeline and sets num_vars to six. When the
// receiver stalls, stages fill up behind the output register, bubbles are
// squeezed out, and the input is held off only once every stage is full.
// ----------------------------------------------------------------------------
module post_class_classifier
    import pcc_pkg::*;
#(
    parameter int MAX_VARS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_num_vars,
    input  logic        i_valid,
    output logic        o_ready_in,
    input  logic [63:0] i_truth_table,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_not_zero_preserving,
    output logic        o_not_one_preserving,
    output logic        o_not_self_dual,
    output logic        o_not_monotone,
    output logic        o_not_linear,
    output logic        o_complete
);

    // Configuration register, kept raw; it is clamped when an item enters.
    t_vars r_num_vars;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars <= t_vars'(6);
        end else if (i_cfg_valid) begin
            r_num_vars <= i_num_vars;
        end
    end

    // Stage registers. Valid bits travel with the data.
    logic   r_v1, r_v2, r_v3, r_v4;
    t_table r_t1, r_anf2, r_anf3;
    t_vars  r_n1, r_n2;
    logic   r_nz2, r_no2, r_nsd2, r_nm2;
    logic   r_nz3, r_no3, r_nsd3, r_nm3;

    // A stage may load when it is empty or its contents move on.
    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4       = !r_v4 || i_ready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_ready_in = rdy1;

    // Effective variable count.
    t_vars n_vars;
    always_comb begin
        n_vars = r_num_vars;
        if (n_vars == t_vars'(0)) begin
            n_vars = t_vars'(1);
        end
        if (n_vars > t_vars'(MAX_VARS)) begin
            n_vars = t_vars'(MAX_VARS);
        end
    end

    // Stage 1: capture the table with the rows that do not exist cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_t1 <= i_truth_table & row_mask(n_vars);
            r_n1 <= n_vars;
        end
    end

    // Stage 2 logic: preserving flags, self-duality, monotonicity and the
    // first three butterfly steps.
    logic   n_nz, n_no, n_nsd, n_nm;
    t_table anf_lo;
    logic [LIMIT_VARS:1] sd_fail;

    always_comb begin
        logic [5:0] top_row;
        top_row = 6'((7'd1 << r_n1) - 7'd1);
        n_nz    = r_t1[0];
        n_no    = !r_t1[top_row];

        // For each table size, a row equal to its complement row breaks
        // self-duality. Only the lower half of the rows needs checking.
        for (int k = 1; k <= LIMIT_VARS; k++) begin
            sd_fail[k] = 1'b0;
            for (int i = 0; i < (1 << (k - 1)); i++) begin
                if (r_t1[i] == r_t1[(1 << k) - 1 - i]) begin
                    sd_fail[k] = 1'b1;
                end
            end
        end
        n_nsd = 1'b0;
        for (int k = 1; k <= LIMIT_VARS; k++) begin
            if (r_n1 == t_vars'(k)) begin
                n_nsd = sd_fail[k];
            end
        end

        // A one followed by a zero when a single variable rises.
        n_nm = 1'b0;
        for (int j = 0; j < LIMIT_VARS; j++) begin
            if (t_vars'(j) < r_n1) begin
                if (|(r_t1 & LOW_HALF_MASK[j] & ~(r_t1 >> (1 << j)))) begin
                    n_nm = 1'b1;
                end
            end
        end
    end

    pcc_mobius #(
        .FIRST_STEP (0),
        .LAST_STEP  (2)
    ) u_mobius_lo (
        .i_table (r_t1),
        .i_vars  (r_n1),
        .o_table (anf_lo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_nz2  <= n_nz;
            r_no2  <= n_no;
            r_nsd2 <= n_nsd;
            r_nm2  <= n_nm;
            r_anf2 <= anf_lo;
            r_n2   <= r_n1;
        end
    end

    // Stage 3: the remaining butterfly steps.
    t_table anf_hi;

    pcc_mobius #(
        .FIRST_STEP (3),
        .LAST_STEP  (5)
    ) u_mobius_hi (
        .i_table (r_anf2),
        .i_vars  (r_n2),
        .o_table (anf_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r_nz3  <= r_nz2;
            r_no3  <= r_no2;
            r_nsd3 <= r_nsd2;
            r_nm3  <= r_nm2;
            r_anf3 <= anf_hi;
        end
    end

    // Stage 4: the masked table has no terms above its own rows, so any ANF
    // coefficient on a row of weight two or more makes the function nonlinear.
    logic n_nl;
    assign n_nl = |(r_anf3 & NONLINEAR_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            o_not_zero_preserving <= r_nz3;
            o_not_one_preserving  <= r_no3;
            o_not_self_dual       <= r_nsd3;
            o_not_monotone        <= r_nm3;
            o_not_linear          <= n_nl;
            o_complete            <= r_nz3 & r_no3 & r_nsd3 & r_nm3 & n_nl;
        end
    end

    assign o_valid = r_v4;

    // The input is only held off when every stage is full and the output stalls.
    a_backpressure_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready_in |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_ready))
        else $error("input held off without a full, stalled pipeline");

    // An accepted item reaches the first stage on the next edge.
    a_capture : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready_in) |=> r_v1)
        else $error("accepted item did not enter the first stage");

    // A new result appears only when stage three held an item.
    a_result_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(r_v3))
        else $error("result appeared with an empty stage three");

    // A held middle stage keeps its item while the stage after it is full and stalled.
    a_stage2_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !rdy3) |=> r_v2)
        else $error("stalled item lost from stage two");

endmodule
